FILE: rtl/gotsr_pkg.sv
// Shared types and constants of the glyph outline to shape record encoder.
// Used by the front end, back end and top level under rtl/; depends on nothing.
`timescale 1ns / 1ps

package gotsr_pkg;

  localparam int OP_W       = 3;
  localparam int NUM_BITS_W = 5;

  // Outline command codes on in_operation; 5 to 7 carry no meaning.
  localparam logic [OP_W-1:0] OP_MOVE  = 3'd0;
  localparam logic [OP_W-1:0] OP_LINE  = 3'd1;
  localparam logic [OP_W-1:0] OP_QUAD  = 3'd2;
  localparam logic [OP_W-1:0] OP_CUBIC = 3'd3;
  localparam logic [OP_W-1:0] OP_END   = 3'd4;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_CURVE = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  // Control part of one command from the front to the back.
  typedef struct packed {
    kind_t kind;
    logic  last;
  } cmd_ctl_t;

  // Control part of one finished shape record.
  typedef struct packed {
    kind_t                 kind;
    logic                  set_styles;
    logic                  vertical_line;
    logic                  general_line;
    logic [NUM_BITS_W-1:0] num_bits;
    logic                  last_record;
  } rec_ctl_t;

endpackage

FILE: rtl/gotsr_fifo.sv
// Small first-in first-out queue of packed words, flip-flop storage.
// Generic; no package needed.
`timescale 1ns / 1ps

module gotsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/gotsr_front.sv
// Front end: accepts outline commands, drops undefined ones, forms the cubic
// midpoint and issues one segment command per cycle unless cmd_full; uses gotsr_pkg.
`timescale 1ns / 1ps

module gotsr_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [gotsr_pkg::OP_W-1:0]         in_operation,
  input  logic signed [COORD_BITS-1:0]       in_end_x,
  input  logic signed [COORD_BITS-1:0]       in_end_y,
  input  logic signed [COORD_BITS-1:0]       in_ctrl1_x,
  input  logic signed [COORD_BITS-1:0]       in_ctrl1_y,
  input  logic signed [COORD_BITS-1:0]       in_ctrl2_x,
  input  logic signed [COORD_BITS-1:0]       in_ctrl2_y,
  output logic                               cmd_push,
  output logic [$bits(gotsr_pkg::cmd_ctl_t)+4*COORD_BITS-1:0] cmd_word,
  input  logic                               cmd_full
);

  localparam int CB = COORD_BITS;

  logic                          hold_valid_r, hold_valid_nxt;
  logic                          second_r, second_nxt;
  logic [gotsr_pkg::OP_W-1:0]    op_r;
  logic [CB-1:0]                 ex_r, ey_r, c1x_r, c1y_r, c2x_r, c2y_r, mx_r, my_r;
  logic [CB:0]                   sum_x, sum_y, adj_x, adj_y;
  logic                          accept, op_ok, is_cubic, done;
  gotsr_pkg::cmd_ctl_t           ctl;
  logic [CB-1:0]                 cx, cy, ax, ay;

  // Midpoint of the two control points, truncated toward zero.
  assign sum_x = {in_ctrl1_x[CB-1], in_ctrl1_x} + {in_ctrl2_x[CB-1], in_ctrl2_x};
  assign sum_y = {in_ctrl1_y[CB-1], in_ctrl1_y} + {in_ctrl2_y[CB-1], in_ctrl2_y};
  assign adj_x = sum_x + {{CB{1'b0}}, sum_x[CB]};
  assign adj_y = sum_y + {{CB{1'b0}}, sum_y[CB]};

  assign op_ok    = op_r inside {[gotsr_pkg::OP_MOVE:gotsr_pkg::OP_END]};
  assign is_cubic = (op_r == gotsr_pkg::OP_CUBIC);
  assign cmd_push = hold_valid_r && op_ok && !cmd_full;
  assign done     = hold_valid_r && (!op_ok || (!cmd_full && (!is_cubic || second_r)));
  assign in_full  = hold_valid_r && !done;
  assign accept   = in_push && !in_full;

  always_comb begin
    ctl.kind = gotsr_pkg::KIND_END;
    ctl.last = 1'b1;
    cx = '0;
    cy = '0;
    ax = ex_r;
    ay = ey_r;
    case (op_r)
      gotsr_pkg::OP_MOVE: ctl.kind = gotsr_pkg::KIND_MOVE;
      gotsr_pkg::OP_LINE: ctl.kind = gotsr_pkg::KIND_LINE;
      gotsr_pkg::OP_QUAD: begin
        ctl.kind = gotsr_pkg::KIND_CURVE;
        cx = c1x_r;
        cy = c1y_r;
      end
      gotsr_pkg::OP_CUBIC: begin
        ctl.kind = gotsr_pkg::KIND_CURVE;
        if (second_r) begin
          cx = c2x_r;
          cy = c2y_r;
        end else begin
          ctl.last = 1'b0;
          cx = c1x_r;
          cy = c1y_r;
          ax = mx_r;
          ay = my_r;
        end
      end
      default: begin
        ctl.kind = gotsr_pkg::KIND_END;
        ax = '0;
        ay = '0;
      end
    endcase
  end

  assign cmd_word = {ctl, cx, cy, ax, ay};

  always_comb begin
    hold_valid_nxt = accept || (hold_valid_r && !done);
    second_nxt     = second_r;
    if (accept) begin
      second_nxt = 1'b0;
    end else if (cmd_push && is_cubic && !second_r) begin
      second_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      second_r     <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      second_r     <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      ex_r  <= in_end_x;
      ey_r  <= in_end_y;
      c1x_r <= in_ctrl1_x;
      c1y_r <= in_ctrl1_y;
      c2x_r <= in_ctrl2_x;
      c2y_r <= in_ctrl2_y;
      mx_r  <= adj_x[CB:1];
      my_r  <= adj_y[CB:1];
    end
  end

endmodule

FILE: rtl/gotsr_back.sv
// Back end: scales command points, measures them against the pen, drops
// repeated moves and zero lines, sizes the record. Uses gotsr_pkg.
`timescale 1ns / 1ps

module gotsr_back #(
  parameter int COORD_BITS      = 16,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [SCALE_FRAC_BITS+1:0]            scale,
  input  logic                                  cmd_empty,
  input  logic [$bits(gotsr_pkg::cmd_ctl_t)+4*COORD_BITS-1:0] cmd_word,
  output logic                                  cmd_pop,
  output logic                                  rec_push,
  output logic [$bits(gotsr_pkg::rec_ctl_t)+4*(COORD_BITS+3)-1:0] rec_word,
  input  logic                                  rec_full
);

  localparam int CB   = COORD_BITS;
  localparam int FRAC = SCALE_FRAC_BITS;
  localparam int SW   = SCALE_FRAC_BITS + 2;
  localparam int PRW  = CB + SW;
  localparam int PNW  = CB + 2;
  localparam int DW   = CB + 3;
  localparam int MW   = CB + 2;
  localparam int CTLW = $bits(gotsr_pkg::cmd_ctl_t);
  localparam int NBW  = gotsr_pkg::NUM_BITS_W;

  logic                adv;
  gotsr_pkg::cmd_ctl_t cmd_ctl;
  logic [CB-1:0]       cmd_pt [4];
  logic [CB-1:0]       mag    [4];
  logic [PRW-1:0]      prod   [4];

  logic                s1_valid_r;
  gotsr_pkg::cmd_ctl_t s1_ctl_r;
  logic [PRW-1:0]      s1_prod_r [4];
  logic                s1_neg_r  [4];

  logic [PRW-FRAC-1:0] shifted [4];
  logic [CB:0]         satm    [4];
  logic [PNW-1:0]      scaled  [4];

  logic                s2_valid_r;
  gotsr_pkg::cmd_ctl_t s2_ctl_r;
  logic [PNW-1:0]      s2_pt_r [4];

  logic [PNW-1:0]      pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic                pen_known_r, pen_known_nxt, started_r, started_nxt;

  logic [DW-1:0]       ecx, ecy, eax, eay, epx, epy;
  logic [DW-1:0]       d_nxt [4];
  logic                sup, styles_nxt, vert_nxt, gen_nxt;

  logic                s3_valid_r;
  gotsr_pkg::kind_t    s3_kind_r;
  logic                s3_styles_r, s3_vert_r, s3_gen_r, s3_last_r;
  logic [DW-1:0]       s3_d_r [4];

  logic [MW-1:0]       dmag [4];
  logic [MW-1:0]       max_a, max_b, max_m;
  logic [MW-1:0]       therm;
  logic [NBW-1:0]      sb, nb;
  gotsr_pkg::rec_ctl_t rctl;

  assign adv     = !(s3_valid_r && rec_full);
  assign cmd_pop = adv && !cmd_empty;

  // Point order: 0 control x, 1 control y, 2 anchor x, 3 anchor y.
  assign cmd_ctl   = gotsr_pkg::cmd_ctl_t'(cmd_word[CTLW+4*CB-1 -: CTLW]);
  assign cmd_pt[0] = cmd_word[4*CB-1 -: CB];
  assign cmd_pt[1] = cmd_word[3*CB-1 -: CB];
  assign cmd_pt[2] = cmd_word[2*CB-1 -: CB];
  assign cmd_pt[3] = cmd_word[CB-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i]  = cmd_pt[i][CB-1] ? (~cmd_pt[i] + CB'(1)) : cmd_pt[i];
      prod[i] = PRW'(mag[i]) * PRW'(scale);
    end
  end

  // Saturate the scaled magnitude, restore the sign and negate y.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shifted[i] = s1_prod_r[i][PRW-1:FRAC];
      satm[i]    = shifted[i][CB+1] ? '1 : shifted[i][CB:0];
      scaled[i]  = s1_neg_r[i] ? (~{1'b0, satm[i]} + PNW'(1)) : {1'b0, satm[i]};
    end
  end

  assign ecx = {s2_pt_r[0][PNW-1], s2_pt_r[0]};
  assign ecy = {s2_pt_r[1][PNW-1], s2_pt_r[1]};
  assign eax = {s2_pt_r[2][PNW-1], s2_pt_r[2]};
  assign eay = {s2_pt_r[3][PNW-1], s2_pt_r[3]};
  assign epx = {pen_x_r[PNW-1], pen_x_r};
  assign epy = {pen_y_r[PNW-1], pen_y_r};

  always_comb begin
    sup        = 1'b0;
    styles_nxt = 1'b0;
    vert_nxt   = 1'b0;
    gen_nxt    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      d_nxt[i] = '0;
    end
    case (s2_ctl_r.kind)
      gotsr_pkg::KIND_MOVE: begin
        sup        = pen_known_r && (s2_pt_r[2] == pen_x_r) && (s2_pt_r[3] == pen_y_r);
        styles_nxt = !started_r;
        d_nxt[0]   = eax;
        d_nxt[1]   = eay;
      end
      gotsr_pkg::KIND_LINE: begin
        d_nxt[0] = eax - epx;
        d_nxt[1] = eay - epy;
        sup      = (d_nxt[0] == '0) && (d_nxt[1] == '0);
        vert_nxt = (d_nxt[0] == '0);
        gen_nxt  = (d_nxt[0] != '0) && (d_nxt[1] != '0);
      end
      gotsr_pkg::KIND_CURVE: begin
        d_nxt[0] = eax - ecx;
        d_nxt[1] = eay - ecy;
        d_nxt[2] = ecx - epx;
        d_nxt[3] = ecy - epy;
      end
      default: begin
        sup = 1'b0;
      end
    endcase
  end

  always_comb begin
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    pen_known_nxt = pen_known_r;
    started_nxt   = started_r;
    if (adv && s2_valid_r && !sup) begin
      if (s2_ctl_r.kind == gotsr_pkg::KIND_END) begin
        pen_x_nxt     = '0;
        pen_y_nxt     = '0;
        pen_known_nxt = 1'b0;
        started_nxt   = 1'b0;
      end else begin
        pen_x_nxt     = s2_pt_r[2];
        pen_y_nxt     = s2_pt_r[3];
        pen_known_nxt = 1'b1;
        started_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      pen_known_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= !cmd_empty;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r && !sup;
      end
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      pen_known_r <= pen_known_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r    <= cmd_ctl;
      s2_ctl_r    <= s1_ctl_r;
      s3_kind_r   <= s2_ctl_r.kind;
      s3_last_r   <= s2_ctl_r.last;
      s3_styles_r <= styles_nxt;
      s3_vert_r   <= vert_nxt;
      s3_gen_r    <= gen_nxt;
      for (int i = 0; i < 4; i++) begin
        s1_prod_r[i] <= prod[i];
        s1_neg_r[i]  <= cmd_pt[i][CB-1] ^ i[0];
        s2_pt_r[i]   <= scaled[i];
        s3_d_r[i]    <= d_nxt[i];
      end
    end
  end

  // Record size from the largest delta magnitude.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dmag[i] = s3_d_r[i][DW-1] ? MW'(~s3_d_r[i] + DW'(1)) : s3_d_r[i][MW-1:0];
    end
    max_a = (dmag[0] > dmag[1]) ? dmag[0] : dmag[1];
    max_b = (dmag[2] > dmag[3]) ? dmag[2] : dmag[3];
    max_m = (max_a > max_b) ? max_a : max_b;
    for (int i = 0; i < MW; i++) begin
      therm[i] = |(max_m >> i);
    end
    sb = NBW'($countones(therm)) + NBW'(1);
    case (s3_kind_r)
      gotsr_pkg::KIND_MOVE: nb = sb;
      gotsr_pkg::KIND_END:  nb = '0;
      default:              nb = (sb < NBW'(3)) ? NBW'(1) : sb - NBW'(2);
    endcase
  end

  assign rctl.kind          = s3_kind_r;
  assign rctl.set_styles    = s3_styles_r;
  assign rctl.vertical_line = s3_vert_r;
  assign rctl.general_line  = s3_gen_r;
  assign rctl.num_bits      = nb;
  assign rctl.last_record   = s3_last_r;

  assign rec_push = s3_valid_r && !rec_full;
  assign rec_word = {rctl, s3_d_r[0], s3_d_r[1], s3_d_r[2], s3_d_r[3]};

endmodule

FILE: rtl/glyph_outline_to_shape_records_core.sv
// Top level of the glyph outline to shape record encoder: scale register,
// front end, command queue, back end and result queue. Uses gotsr_pkg.
//
//   channel   ports                           accepted when
//   input     in_push / in_full + fields      in_push && !in_full
//   result    out_pop / out_empty + fields    out_pop && !out_empty
//   config    cfg_we / cfg_wdata              cfg_we
//
// Flow: the front end holds one item at a time, splits a cubic into two segments
// and issues one segment a cycle into the back pipeline (scale, measure, size)
// while the command queue has room; it takes a new item as the last segment goes.
// Reset: synchronous rst_n clears queues, pipeline valids and pen; scale = 1.0.
// Stalls: a full result queue halts the back end; the two-entry command
// queue lets the front keep accepting until it fills.
`timescale 1ns / 1ps

module glyph_outline_to_shape_records_core #(
  parameter int COORD_BITS      = 16,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [SCALE_FRAC_BITS+1:0]         cfg_wdata,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [gotsr_pkg::OP_W-1:0]         in_operation,
  input  logic signed [COORD_BITS-1:0]       in_end_x,
  input  logic signed [COORD_BITS-1:0]       in_end_y,
  input  logic signed [COORD_BITS-1:0]       in_ctrl1_x,
  input  logic signed [COORD_BITS-1:0]       in_ctrl1_y,
  input  logic signed [COORD_BITS-1:0]       in_ctrl2_x,
  input  logic signed [COORD_BITS-1:0]       in_ctrl2_y,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [1:0]                         out_record_kind,
  output logic                               out_set_styles,
  output logic                               out_vertical_line,
  output logic                               out_general_line,
  output logic [gotsr_pkg::NUM_BITS_W-1:0]   out_num_bits,
  output logic signed [COORD_BITS+2:0]       out_delta_x,
  output logic signed [COORD_BITS+2:0]       out_delta_y,
  output logic signed [COORD_BITS+2:0]       out_control_dx,
  output logic signed [COORD_BITS+2:0]       out_control_dy,
  output logic                               out_last_record
);

  localparam int SW     = SCALE_FRAC_BITS + 2;
  localparam int DW     = COORD_BITS + 3;
  localparam int CMD_W  = $bits(gotsr_pkg::cmd_ctl_t) + 4 * COORD_BITS;
  localparam int RCTL_W = $bits(gotsr_pkg::rec_ctl_t);
  localparam int REC_W  = RCTL_W + 4 * DW;

  logic [SW-1:0]       scale_r;
  logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0]    cmd_wdata, cmd_rdata;
  logic                rec_push, rec_full;
  logic [REC_W-1:0]    rec_wdata, rec_rdata;
  gotsr_pkg::rec_ctl_t rctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SW'(1) << SCALE_FRAC_BITS;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  gotsr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_operation(in_operation),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .in_ctrl1_x  (in_ctrl1_x),
    .in_ctrl1_y  (in_ctrl1_y),
    .in_ctrl2_x  (in_ctrl2_x),
    .in_ctrl2_y  (in_ctrl2_y),
    .cmd_push    (cmd_push),
    .cmd_word    (cmd_wdata),
    .cmd_full    (cmd_full)
  );

  gotsr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .wdata(cmd_wdata),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_rdata),
    .empty(cmd_empty)
  );

  gotsr_back #(
    .COORD_BITS     (COORD_BITS),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .scale    (scale_r),
    .cmd_empty(cmd_empty),
    .cmd_word (cmd_rdata),
    .cmd_pop  (cmd_pop),
    .rec_push (rec_push),
    .rec_word (rec_wdata),
    .rec_full (rec_full)
  );

  gotsr_fifo #(
    .WIDTH(REC_W),
    .DEPTH(4)
  ) u_rec_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (rec_push),
    .wdata(rec_wdata),
    .full (rec_full),
    .pop  (out_pop),
    .rdata(rec_rdata),
    .empty(out_empty)
  );

  assign rctl              = gotsr_pkg::rec_ctl_t'(rec_rdata[REC_W-1 -: RCTL_W]);
  assign out_record_kind   = rctl.kind;
  assign out_set_styles    = rctl.set_styles;
  assign out_vertical_line = rctl.vertical_line;
  assign out_general_line  = rctl.general_line;
  assign out_num_bits      = rctl.num_bits;
  assign out_last_record   = rctl.last_record;
  assign out_delta_x       = rec_rdata[4*DW-1 -: DW];
  assign out_delta_y       = rec_rdata[3*DW-1 -: DW];
  assign out_control_dx    = rec_rdata[2*DW-1 -: DW];
  assign out_control_dy    = rec_rdata[DW-1:0];

endmodule

FILE: dv/glyph_outline_to_shape_records_core_test.sv
// Self-checking test of glyph_outline_to_shape_records_core: outline commands in,
// shape records out, each record checked against an in-bench encoder model.
// Depends on rtl/gotsr_pkg.sv and rtl/glyph_outline_to_shape_records_core.sv.
`timescale 1ns / 1ps

module glyph_outline_to_shape_records_core_test;
  import gotsr_pkg::*;

  localparam int COORD_BITS      = 16;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int DW              = COORD_BITS + 3;
  localparam int PEN_MAX         = (1 << (COORD_BITS + 1)) - 1;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int IDLE_PCT        = 23;

  typedef struct {
    logic [OP_W-1:0]              op;
    logic signed [COORD_BITS-1:0] ex, ey, c1x, c1y, c2x, c2y;
  } outline_cmd_t;

  typedef struct {
    kind_t                 kind;
    logic                  set_styles;
    logic                  vertical_line;
    logic                  general_line;
    logic [NUM_BITS_W-1:0] num_bits;
    logic signed [DW-1:0]  delta_x, delta_y, control_dx, control_dy;
    logic                  last_record;
  } shape_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [SCALE_FRAC_BITS+1:0] cfg_wdata = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [OP_W-1:0] in_operation = '0;
  logic signed [COORD_BITS-1:0] in_end_x = '0, in_end_y = '0;
  logic signed [COORD_BITS-1:0] in_ctrl1_x = '0, in_ctrl1_y = '0;
  logic signed [COORD_BITS-1:0] in_ctrl2_x = '0, in_ctrl2_y = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [1:0] out_record_kind;
  logic out_set_styles, out_vertical_line, out_general_line, out_last_record;
  logic [NUM_BITS_W-1:0] out_num_bits;
  logic signed [DW-1:0] out_delta_x, out_delta_y, out_control_dx, out_control_dy;

  glyph_outline_to_shape_records_core #(
    .COORD_BITS      (COORD_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_operation      (in_operation),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_ctrl1_x        (in_ctrl1_x),
    .in_ctrl1_y        (in_ctrl1_y),
    .in_ctrl2_x        (in_ctrl2_x),
    .in_ctrl2_y        (in_ctrl2_y),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_record_kind   (out_record_kind),
    .out_set_styles    (out_set_styles),
    .out_vertical_line (out_vertical_line),
    .out_general_line  (out_general_line),
    .out_num_bits      (out_num_bits),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_control_dx    (out_control_dx),
    .out_control_dy    (out_control_dy),
    .out_last_record   (out_last_record)
  );

  always #10 clk = ~clk;

  outline_cmd_t outline_cmds[$];
  shape_rec_t   shape_records_due[$];
  shape_rec_t   due;

  // Encoder state as the block should hold it.
  logic [SCALE_FRAC_BITS+1:0]   scale_cfg = 18'd65536;
  logic signed [COORD_BITS+1:0] pen_x = '0, pen_y = '0;
  logic                         pen_known = 1'b0;
  logic                         glyph_started = 1'b0;

  int  mismatches = 0;
  int  cycles = 0;
  int  real_cmds = 0;
  int  rx_hold = 0;
  bit  cmd_taken = 0;
  bit  tx_steady = 0;
  bit  rx_steady = 0;
  logic signed [COORD_BITS-1:0] gen_x = '0, gen_y = '0;

  function automatic int scaled(input int v);
    longint mag, p;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    p = (mag * longint'(scale_cfg)) >> SCALE_FRAC_BITS;
    if (p > PEN_MAX) p = PEN_MAX;
    return (v < 0) ? -int'(p) : int'(p);
  endfunction

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int sig_bits(input int m);
    int n;
    n = 0;
    while (n < 31 && (m >> n) != 0) n++;
    return n + 1;
  endfunction

  function automatic int edge_bits(input int m);
    int b;
    b = sig_bits(m);
    if (b < 3) b = 3;
    return b - 2;
  endfunction

  function automatic shape_rec_t make_rec(input kind_t kind, input logic styles,
                                          input logic vert, input logic gen,
                                          input int nb, input int dx, input int dy,
                                          input int cx, input int cy, input logic last);
    shape_rec_t r;
    r.kind          = kind;
    r.set_styles    = styles;
    r.vertical_line = vert;
    r.general_line  = gen;
    r.num_bits      = NUM_BITS_W'(nb);
    r.delta_x       = DW'(dx);
    r.delta_y       = DW'(dy);
    r.control_dx    = DW'(cx);
    r.control_dy    = DW'(cy);
    r.last_record   = last;
    return r;
  endfunction

  // Curve from the pen through (cx,cy) to (ax,ay); advance the pen.
  function automatic void emit_curve(input int cx, input int cy, input int ax,
                                     input int ay, input logic last);
    int dax, day, dcx, dcy, m;
    dax = ax - cx;
    day = ay - cy;
    dcx = cx - pen_x;
    dcy = cy - pen_y;
    m = mag(dax);
    if (mag(day) > m) m = mag(day);
    if (mag(dcx) > m) m = mag(dcx);
    if (mag(dcy) > m) m = mag(dcy);
    shape_records_due.push_back(make_rec(KIND_CURVE, 1'b0, 1'b0, 1'b0, edge_bits(m),
                                         dax, day, dcx, dcy, last));
    pen_x = ax;
    pen_y = ay;
    pen_known = 1'b1;
    glyph_started = 1'b1;
  endfunction

  function automatic void encode_command(input outline_cmd_t c);
    int x, y, dx, dy, m, mx, my;
    x = scaled(c.ex);
    y = -scaled(c.ey);
    case (c.op)
      OP_MOVE: begin
        if (!(pen_known && x == pen_x && y == pen_y)) begin
          m = (mag(x) > mag(y)) ? mag(x) : mag(y);
          shape_records_due.push_back(make_rec(KIND_MOVE, !glyph_started, 1'b0, 1'b0,
                                               sig_bits(m), x, y, 0, 0, 1'b1));
          pen_x = x;
          pen_y = y;
          pen_known = 1'b1;
          glyph_started = 1'b1;
        end
      end
      OP_LINE: begin
        dx = x - pen_x;
        dy = y - pen_y;
        if (dx != 0 || dy != 0) begin
          m = (mag(dx) > mag(dy)) ? mag(dx) : mag(dy);
          shape_records_due.push_back(make_rec(KIND_LINE, 1'b0, dx == 0,
                                               dx != 0 && dy != 0, edge_bits(m),
                                               dx, dy, 0, 0, 1'b1));
          pen_x = x;
          pen_y = y;
          pen_known = 1'b1;
          glyph_started = 1'b1;
        end
      end
      OP_QUAD: emit_curve(scaled(c.c1x), -scaled(c.c1y), x, y, 1'b1);
      OP_CUBIC: begin
        // Split at the control midpoint, truncated toward zero in font units.
        mx = (int'(c.c1x) + int'(c.c2x)) / 2;
        my = (int'(c.c1y) + int'(c.c2y)) / 2;
        emit_curve(scaled(c.c1x), -scaled(c.c1y), scaled(mx), -scaled(my), 1'b0);
        emit_curve(scaled(c.c2x), -scaled(c.c2y), x, y, 1'b1);
      end
      OP_END: begin
        shape_records_due.push_back(make_rec(KIND_END, 1'b0, 1'b0, 1'b0, 0,
                                             0, 0, 0, 0, 1'b1));
        pen_x = '0;
        pen_y = '0;
        pen_known = 1'b0;
        glyph_started = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: check the result channel first, then take in the accepted item.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (shape_records_due.size() == 0) begin
          $error("record_kind: expected no record, got %0d", out_record_kind);
          mismatches++;
        end else begin
          due = shape_records_due.pop_front();
          check_field("record_kind", due.kind, out_record_kind);
          check_field("set_styles", due.set_styles, out_set_styles);
          check_field("vertical_line", due.vertical_line, out_vertical_line);
          check_field("general_line", due.general_line, out_general_line);
          check_field("num_bits", due.num_bits, out_num_bits);
          check_field("delta_x", due.delta_x, out_delta_x);
          check_field("delta_y", due.delta_y, out_delta_y);
          check_field("control_dx", due.control_dx, out_control_dx);
          check_field("control_dy", due.control_dy, out_control_dy);
          check_field("last_record", due.last_record, out_last_record);
        end
      end
      if (in_push && !in_full) begin
        encode_command(outline_cmds.pop_front());
        cmd_taken = 1;
      end
    end
  end

  // Driver: hold an offered item until it is taken, then offer the next one.
  always @(negedge clk) begin
    if (!(in_push && !cmd_taken)) begin
      if (outline_cmds.size() > 0 && (tx_steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_push      <= 1'b1;
        in_operation <= outline_cmds[0].op;
        in_end_x     <= outline_cmds[0].ex;
        in_end_y     <= outline_cmds[0].ey;
        in_ctrl1_x   <= outline_cmds[0].c1x;
        in_ctrl1_y   <= outline_cmds[0].c1y;
        in_ctrl2_x   <= outline_cmds[0].c2x;
        in_ctrl2_y   <= outline_cmds[0].c2y;
      end else begin
        in_push <= 1'b0;
      end
    end
    cmd_taken = 0;
  end

  // Receiver: random stalls, plus a counted hold-off on request.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return COORD_BITS'($urandom);
      4, 5, 6:    return COORD_BITS'($urandom_range(600) - 300);
      7: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return -16'sh8000;
          2: return 16'sh0000;
          default: return -16'sh0001;
        endcase
      end
      default: return COORD_BITS'(int'(gen_x) + $urandom_range(8) - 4);
    endcase
  endfunction

  task automatic add_cmd(input logic [OP_W-1:0] op, input int ex, input int ey,
                         input int c1x, input int c1y, input int c2x, input int c2y);
    outline_cmd_t c;
    c.op  = op;
    c.ex  = COORD_BITS'(ex);
    c.ey  = COORD_BITS'(ey);
    c.c1x = COORD_BITS'(c1x);
    c.c1y = COORD_BITS'(c1y);
    c.c2x = COORD_BITS'(c2x);
    c.c2y = COORD_BITS'(c2y);
    outline_cmds.push_back(c);
    if (op <= OP_END) real_cmds++;
    if (op == OP_END) begin
      gen_x = '0;
      gen_y = '0;
    end else if (op < OP_END) begin
      gen_x = c.ex;
      gen_y = c.ey;
    end
  endtask

  task automatic add_glyph();
    logic signed [COORD_BITS-1:0] px, py;
    px = rand_coord();
    py = rand_coord();
    add_cmd(OP_MOVE, px, py, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(5) == 0)
      add_cmd(OP_MOVE, px, py, $urandom, $urandom, $urandom, $urandom);
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(9))
        0: add_cmd(OP_LINE, gen_x, gen_y, $urandom, $urandom, $urandom, $urandom);
        1, 2, 3: add_cmd(OP_LINE, rand_coord(), rand_coord(), $urandom, $urandom,
                         $urandom, $urandom);
        4, 5, 6: add_cmd(OP_QUAD, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), $urandom, $urandom);
        7, 8: add_cmd(OP_CUBIC, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        default: add_cmd(OP_MOVE, ($urandom_range(1)) ? gen_x : rand_coord(),
                         ($urandom_range(1)) ? gen_y : rand_coord(),
                         $urandom, $urandom, $urandom, $urandom);
      endcase
    end
    // Leave some glyphs open so the next one continues without style flags.
    if ($urandom_range(7) != 0)
      add_cmd(OP_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic add_random(input int n);
    int start;
    start = real_cmds;
    while (real_cmds - start < n) begin
      if ($urandom_range(99) < 85)
        add_glyph();
      else
        add_cmd(OP_W'($urandom_range(7)), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // Wait until every item is taken and every record has arrived.
  task automatic settle();
    while (outline_cmds.size() != 0 || shape_records_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= (SCALE_FRAC_BITS + 2)'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    scale_cfg = (SCALE_FRAC_BITS + 2)'(value);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_scale(65536);
    add_cmd(OP_END, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_MOVE, 0, 0, -1, -1, -1, -1);
    add_cmd(OP_MOVE, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_LINE, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_LINE, 0, 100, 0, 0, 0, 0);
    add_cmd(OP_LINE, 300, 100, 0, 0, 0, 0);
    add_cmd(OP_LINE, -50, -70, 0, 0, 0, 0);
    add_cmd(OP_QUAD, 20, -5, 10, 10, 0, 0);
    add_cmd(OP_CUBIC, 32767, -32768, -32768, -32768, -32767, 32767);
    add_cmd(OP_MOVE, 32767, -32768, 0, 0, 0, 0);
    add_cmd(3'd5, 1, 2, 3, 4, 5, 6);
    add_cmd(3'd6, -1, -1, -1, -1, -1, -1);
    add_cmd(3'd7, 32767, -32768, 32767, -32768, 32767, -32768);
    add_cmd(OP_END, -1, -1, -1, -1, -1, -1);
    add_cmd(OP_LINE, -32768, 32767, 0, 0, 0, 0);
    add_cmd(OP_QUAD, -32768, -32768, 32767, 32767, 0, 0);
    add_cmd(OP_CUBIC, 0, 0, -3, 0, 0, 0);
    add_cmd(OP_MOVE, -32768, 32767, 0, 0, 0, 0);
    add_cmd(OP_END, 0, 0, 0, 0, 0, 0);
    add_cmd(OP_CUBIC, 7, -9, 1, 2, -4, 5);
    add_cmd(OP_MOVE, 5, 5, 0, 0, 0, 0);
    add_cmd(OP_END, 0, 0, 0, 0, 0, 0);
    add_random(150);
    settle();

    write_scale(1);
    add_random(120);
    settle();

    // Full scale saturates; stall the receiver so the block backs up.
    write_scale(262143);
    tx_steady = 1;
    add_cmd(OP_MOVE, 32767, -32768, 0, 0, 0, 0);
    add_cmd(OP_LINE, -32768, 32767, 0, 0, 0, 0);
    add_cmd(OP_CUBIC, 32767, 32767, -32768, -32768, -32768, -32768);
    @(posedge clk);
    rx_hold = 200;
    add_random(120);
    settle();
    tx_steady = 0;

    write_scale(0);
    add_random(80);
    settle();

    write_scale(1024);
    tx_steady = 1;
    rx_steady = 1;
    add_random(200);
    settle();
    tx_steady = 0;
    rx_steady = 0;

    repeat (3) begin
      write_scale($urandom_range(262143, 1));
      add_random(140);
      settle();
    end

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gotsr_pkg.sv
rtl/gotsr_fifo.sv
rtl/gotsr_front.sv
rtl/gotsr_back.sv
rtl/glyph_outline_to_shape_records_core.sv
dv/glyph_outline_to_shape_records_core_test.sv
